// ===== sv/icp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package icp_pkg;

    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int OCTET_W    = 8;
    localparam int FIELD_W    = 2;
    localparam int PREFIX_W   = 6;
    localparam int PREFIX_ACC_W = 9;

    localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [FIELD_W-1:0]  LAST_FIELD = 2'd3;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;
    localparam logic [PREFIX_W-1:0] PREFIX_SAT = 6'd33;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_FWS   = 8'b0000_0001,
        PH_FSIGN = 8'b0000_0010,
        PH_FDIG  = 8'b0000_0100,
        PH_FSKIP = 8'b0000_1000,
        PH_PWS   = 8'b0001_0000,
        PH_PSIGN = 8'b0010_0000,
        PH_PDIG  = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [FIELD_W-1:0]    field_idx;
        logic [OCTET_W-1:0]    octet;
        logic                  neg;
        logic [ADDR_W-1:0]     addr;
        logic [ADDR_W-1:0]     mask;
        logic [PREFIX_W-1:0]   prefix;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:     PH_FWS,
        field_idx: '0,
        octet:     '0,
        neg:       1'b0,
        addr:      '0,
        mask:      '0,
        prefix:    '0
    };

endpackage

`default_nettype wire

// ===== sv/icp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module icp_step (
    input  wire logic [icp_pkg::CHAR_W-1:0] i_char,
    input  wire icp_pkg::t_parse_state      i_state,
    output icp_pkg::t_parse_state           o_state,
    output logic [icp_pkg::ADDR_W-1:0]      o_addr,
    output logic [icp_pkg::ADDR_W-1:0]      o_mask
);
    import icp_pkg::*;

    logic                  w_ws;
    logic                  w_digit;
    logic                  w_sign;
    logic                  w_delim;
    logic [3:0]            w_d;
    logic [OCTET_W-1:0]    w_octet_acc;
    logic [PREFIX_ACC_W-1:0] w_prefix_acc;
    t_parse_state          w_commit;
    t_parse_state          w_fin;
    logic [PREFIX_W-1:0]   w_range;
    logic [OCTET_W-1:0]    w_val;

    // '.' or '/' at a field boundary
    function automatic t_parse_state f_delim(input t_parse_state s, input logic [CHAR_W-1:0] c);
        t_parse_state r;
        r = s;
        if (c == CHAR_DOT) begin
            if (s.field_idx == LAST_FIELD) begin
                r.phase = PH_DONE;
            end else begin
                r.field_idx = s.field_idx + 1'b1;
                r.octet     = '0;
                r.neg       = 1'b0;
                r.phase     = PH_FWS;
            end
        end else begin
            r.prefix = '0;
            r.neg    = 1'b0;
            r.phase  = PH_PWS;
        end
        return r;
    endfunction

    assign w_ws    = (i_char == CHAR_SPACE) || ((i_char >= CHAR_TAB) && (i_char <= CHAR_CR));
    assign w_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign w_sign  = (i_char == CHAR_PLUS) || (i_char == CHAR_MINUS);
    assign w_delim = (i_char == CHAR_DOT) || (i_char == CHAR_SLASH);
    assign w_d     = i_char[3:0];

    // times ten plus digit, low byte only
    assign w_octet_acc = {i_state.octet[4:0], 3'b000} + {i_state.octet[6:0], 1'b0}
                       + {4'b0000, w_d};
    assign w_prefix_acc = {i_state.prefix, 3'b000}
                        + {2'b00, i_state.prefix, 1'b0}
                        + {5'b00000, w_d};

    // write the finished field into its byte lane
    always_comb begin
        w_commit = i_state;
        w_val    = i_state.neg ? (~i_state.octet + 1'b1) : i_state.octet;
        w_commit.addr[{~i_state.field_idx, 3'b000} +: OCTET_W] = w_val;
        w_commit.mask[{~i_state.field_idx, 3'b000} +: OCTET_W] = '1;
    end

    always_comb begin
        o_state = i_state;
        if (i_char == CHAR_END) begin
            o_state = PARSE_RESET;
        end else begin
            unique case (i_state.phase)
                PH_FWS, PH_FSIGN: begin
                    if ((i_state.phase == PH_FWS) && w_ws) begin
                        o_state = i_state;
                    end else if ((i_state.phase == PH_FWS) && w_sign) begin
                        o_state.neg   = (i_char == CHAR_MINUS);
                        o_state.phase = PH_FSIGN;
                    end else if (w_digit) begin
                        o_state.octet = {4'b0000, w_d};
                        o_state.phase = PH_FDIG;
                    end else if (w_delim) begin
                        o_state = f_delim(i_state, i_char);
                    end else begin
                        o_state.phase = PH_FSKIP;
                    end
                end
                PH_FDIG: begin
                    if (w_digit) begin
                        o_state.octet = w_octet_acc;
                    end else if (w_delim) begin
                        o_state = f_delim(w_commit, i_char);
                    end else begin
                        o_state       = w_commit;
                        o_state.phase = PH_FSKIP;
                    end
                end
                PH_FSKIP: begin
                    if (w_delim) begin
                        o_state = f_delim(i_state, i_char);
                    end
                end
                PH_PWS, PH_PSIGN: begin
                    if ((i_state.phase == PH_PWS) && w_ws) begin
                        o_state = i_state;
                    end else if ((i_state.phase == PH_PWS) && w_sign) begin
                        o_state.neg   = (i_char == CHAR_MINUS);
                        o_state.phase = PH_PSIGN;
                    end else if (w_digit) begin
                        o_state.prefix = {2'b00, w_d};
                        o_state.phase  = PH_PDIG;
                    end else begin
                        o_state.prefix = '0;
                        o_state.neg    = 1'b0;
                        o_state.phase  = PH_DONE;
                    end
                end
                PH_PDIG: begin
                    if (w_digit) begin
                        o_state.prefix = (w_prefix_acc > PREFIX_ACC_W'(PREFIX_SAT))
                                       ? PREFIX_SAT : w_prefix_acc[PREFIX_W-1:0];
                    end else begin
                        if (i_state.neg) begin
                            o_state.prefix = '0;
                        end
                        o_state.neg   = 1'b0;
                        o_state.phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    o_state = i_state;
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

    // result for the terminating character
    always_comb begin
        w_fin = (i_state.phase == PH_FDIG) ? w_commit : i_state;
        w_range = '0;
        if (((i_state.phase == PH_PDIG) || (i_state.phase == PH_DONE)) && !i_state.neg) begin
            w_range = (i_state.prefix > PREFIX_MAX) ? PREFIX_MAX : i_state.prefix;
        end
        if (w_range == '0) begin
            o_mask = w_fin.mask;
        end else begin
            o_mask = ~({ADDR_W{1'b1}} >> w_range);
        end
        o_addr = w_fin.addr & o_mask;
    end

endmodule

`default_nettype wire

// ===== sv/ip_wildcard_cidr_text_parser.sv =====
// Streaming IPv4 text parser: one character per input beat, dotted fields with
// optional whitespace and sign, fields without digits left as wildcards, and an
// optional '/' prefix length clamped to 32. A zero character ends the string and
// produces one output beat carrying the address (low 32 bits, first field in
// bits 31:24, already masked) and the mask (high 32 bits); the parser then
// starts over. Throughput is one character per clock while the result register can
// take a zero character: a character is held in the input register, then a single
// pass of the phase logic updates the parse state, and for a zero character the
// result is written to the output register. Only a zero character that meets a
// full, stalled output register waits; ordinary characters keep flowing. Upstream
// ready depends combinationally on downstream ready.
`timescale 1ns / 1ps
`default_nettype none

module ip_wildcard_cidr_text_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [icp_pkg::CHAR_W-1:0]    i_s_axis_tdata,  // [7:0] char_code
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [2*icp_pkg::ADDR_W-1:0]       o_m_axis_tdata   // [31:0] ip_address, [63:32] ip_mask
);
    import icp_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [CHAR_W-1:0]    r_in_char;

    // parse state
    t_parse_state         r_state;
    t_parse_state         n_state;

    // result register
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [ADDR_W-1:0]    r_out_mask;

    logic                 w_end;
    logic                 w_adv;
    logic [ADDR_W-1:0]    w_addr;
    logic [ADDR_W-1:0]    w_mask;

    // a terminating character needs room in the result register,
    // any other character always moves on
    assign w_end = (r_in_char == CHAR_END);
    assign w_adv = r_in_valid && (!w_end || !r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = !r_in_valid || w_adv;

    icp_step u_step (
        .i_char  (r_in_char),
        .i_state (r_state),
        .o_state (n_state),
        .o_addr  (w_addr),
        .o_mask  (w_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result beat held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_end) begin
            r_out_addr <= w_addr;
            r_out_mask <= w_mask;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_mask, r_out_addr};

endmodule

`default_nettype wire

// ===== sv/icp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module icp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // address never has bits outside the mask
    a_addr_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[31:0] & ~o_m_axis_tdata[63:32]) == 32'h0))
        else $error("address bits set outside mask");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // input register is empty after reset, so the input is ready
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind ip_wildcard_cidr_text_parser icp_checker u_icp_checker (.*);

`default_nettype wire
